/* src/stepper_wave_drive_sequencer_macros.svh */
// Assertion helpers for the wave drive sequencer.
`ifndef STEPPER_WAVE_DRIVE_SEQUENCER_MACROS_SVH
`define STEPPER_WAVE_DRIVE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swds: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SWDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swds: next-cycle check failed");

`endif

/* src/swds_pkg.sv */
`default_nettype none

package swds_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_TURN   = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RESUME = 3'd4;

    // Coil patterns of the wave sequence
    localparam logic [3:0] PH_OFF  = 4'b0000;
    localparam logic [3:0] PH_0001 = 4'b0001;
    localparam logic [3:0] PH_0010 = 4'b0010;
    localparam logic [3:0] PH_0100 = 4'b0100;
    localparam logic [3:0] PH_1000 = 4'b1000;

    localparam logic [7:0]  PIN_MASK_RESET = 8'h0F;
    localparam logic [30:0] STEPS_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] step_count;
        logic               direction;
        logic [15:0]        tick_divisor;
        logic [7:0]         port_in;
    } t_req;

    typedef struct packed {
        logic        port_write;
        logic [7:0]  port_out;
        logic        is_ready;
        logic [30:0] steps_left;
    } t_res;

endpackage

`default_nettype wire

/* src/swds_if.sv */
`default_nettype none

// Request channel
interface swds_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] step_count;
    logic               direction;
    logic [15:0]        tick_divisor;
    logic [7:0]         port_in;

    modport source (
        output valid, req_type, step_count, direction, tick_divisor, port_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, step_count, direction, tick_divisor, port_in,
        output ready
    );
endinterface

// Result channel
interface swds_res_if;
    logic        valid;
    logic        ready;
    logic        port_write;
    logic [7:0]  port_out;
    logic        is_ready;
    logic [30:0] steps_left;

    modport source (
        output valid, port_write, port_out, is_ready, steps_left,
        input  ready
    );
    modport sink (
        input  valid, port_write, port_out, is_ready, steps_left,
        output ready
    );
endinterface

// Pin mask write channel
interface swds_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_mask;

    modport source (
        output valid, pin_mask,
        input  ready
    );
    modport sink (
        input  valid, pin_mask,
        output ready
    );
endinterface

`default_nettype wire

/* src/stepper_wave_drive_sequencer.sv */
// Wave drive sequencer for one four-coil stepper on an 8-bit port. Each
// request (tick, turn, stop, pause, resume) produces exactly one result, in
// order. One request is taken per clock while the request side is ready; a
// request goes through an input register, is evaluated combinationally
// against the step state and lands in a result register. It moves on from
// the input register once the result register is empty or being taken,
// and the result is taken from there when the result side is ready. The
// request side stays ready while a result waits only as long as the input
// register is empty; with both registers full and the result stalled, the
// request side holds off. The pin mask write channel is always ready and
// must only be used while no request is in flight.
`default_nettype none

`include "stepper_wave_drive_sequencer_macros.svh"

module stepper_wave_drive_sequencer #(
    parameter int unsigned DEFAULT_DIVISOR = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    swds_cfg_if.sink    i_cfg,
    swds_req_if.sink    i_req,
    swds_res_if.source  o_res
);

    logic [7:0]     r_pin_mask;
    logic           r_in_valid;
    swds_pkg::t_req r_in;
    logic           r_out_valid;
    swds_pkg::t_res r_out;

    logic           req_take;
    logic           out_load;
    logic           in_adv;
    swds_pkg::t_res step_res;

    assign out_load  = !r_out_valid || o_res.ready;
    assign in_adv    = r_in_valid && out_load;
    assign req_take  = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_valid || out_load;
    assign i_cfg.ready = 1'b1;

    // Pin mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_mask <= swds_pkg::PIN_MASK_RESET;
        end else if (i_cfg.valid) begin
            r_pin_mask <= i_cfg.pin_mask;
        end
    end

    // Input register: hold the request until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (req_take) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_in.req_type     <= i_req.req_type;
            r_in.step_count   <= i_req.step_count;
            r_in.direction    <= i_req.direction;
            r_in.tick_divisor <= i_req.tick_divisor;
            r_in.port_in      <= i_req.port_in;
        end
    end

    swds_ctrl #(
        .DEFAULT_DIVISOR (DEFAULT_DIVISOR)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_adv),
        .i_req      (r_in),
        .i_pin_mask (r_pin_mask),
        .o_res      (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.port_write = r_out.port_write;
    assign o_res.port_out   = r_out.port_out;
    assign o_res.is_ready   = r_out.is_ready;
    assign o_res.steps_left = r_out.steps_left;

    // A new request never overwrites a staged one that has not moved on
    `SWDS_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, req_take && r_in_valid, out_load)
    // A staged request that moves on shows up as a result next cycle
    `SWDS_ASSERT_NXT(a_adv_to_out, i_clk, i_rst_n, in_adv, o_res.valid)
    // Results that do not write the port carry an all-zero port value
    `SWDS_ASSERT_IMP(a_quiet_port, i_clk, i_rst_n, o_res.valid && !o_res.port_write, o_res.port_out == 8'h00)

endmodule

`default_nettype wire

/* src/swds_coil_map.sv */
`default_nettype none

// Gathers the present phase from the masked port bits, picks the following
// wave pattern (or all off on release) and scatters it back into the port.
module swds_coil_map (
    input  wire logic [7:0] i_port,
    input  wire logic [7:0] i_mask,
    input  wire logic       i_fwd,
    input  wire logic       i_release,
    output logic      [7:0] o_port
);

    logic [3:0] phase;
    logic [3:0] next_phase;
    logic [3:0] pattern;
    logic [7:0] scattered;

    // Gather: the highest set mask bit lands on phase bit 3, lower ones below
    always_comb begin
        automatic logic [3:0] above;
        above = 4'd0;
        phase = swds_pkg::PH_OFF;
        for (int i = 7; i >= 0; i--) begin
            if (i_mask[i]) begin
                if (above < 4'd4) begin
                    phase[2'd3 - above[1:0]] = i_port[i];
                end
                above = above + 4'd1;
            end
        end
    end

    // Advance one step; an odd pattern counts as all off
    always_comb begin
        case (phase)
            swds_pkg::PH_0001: next_phase = i_fwd ? swds_pkg::PH_0010 : swds_pkg::PH_1000;
            swds_pkg::PH_0010: next_phase = i_fwd ? swds_pkg::PH_0100 : swds_pkg::PH_0001;
            swds_pkg::PH_0100: next_phase = i_fwd ? swds_pkg::PH_1000 : swds_pkg::PH_0010;
            swds_pkg::PH_1000: next_phase = i_fwd ? swds_pkg::PH_0001 : swds_pkg::PH_0100;
            default:           next_phase = i_fwd ? swds_pkg::PH_0010 : swds_pkg::PH_1000;
        endcase
    end

    assign pattern = i_release ? swds_pkg::PH_OFF : next_phase;

    // Scatter: pattern bit k onto the k-th set mask bit, extra mask bits get 0
    always_comb begin
        automatic logic [3:0] rank;
        rank = 4'd0;
        scattered = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (i_mask[i]) begin
                if (rank < 4'd4) begin
                    scattered[i] = pattern[rank[1:0]];
                end
                rank = rank + 4'd1;
            end
        end
    end

    assign o_port = (i_port & ~i_mask) | scattered;

endmodule

`default_nettype wire

/* src/swds_ctrl.sv */
`default_nettype none

// Step state: remaining count, direction, tick divider and pause flag.
// Computes the result of the staged request and commits the state on i_fire.
module swds_ctrl #(
    parameter int unsigned DEFAULT_DIVISOR = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire swds_pkg::t_req i_req,
    input  wire logic [7:0]     i_pin_mask,
    output swds_pkg::t_res      o_res
);

    localparam logic [15:0] DIV_RESET = 16'(DEFAULT_DIVISOR);

    logic [30:0] r_steps,   n_steps;
    logic        r_dir,     n_dir;
    logic [15:0] r_div_cnt, n_div_cnt;
    logic [15:0] r_div_rld, n_div_rld;
    logic        r_paused,  n_paused;

    logic [15:0] div_dec;
    logic        expire;
    logic        stepping;
    logic [31:0] neg_count;
    logic [30:0] turn_mag;
    logic [7:0]  coil_port;
    logic        port_write;

    assign div_dec   = r_div_cnt - 16'd1;
    assign expire    = (div_dec == 16'd0);
    assign stepping  = (r_steps != '0) && !r_paused;
    assign neg_count = 32'd0 - i_req.step_count;

    // Magnitude of a turn count, saturated for the most negative value
    always_comb begin
        if (i_req.step_count[31]) begin
            turn_mag = neg_count[31] ? swds_pkg::STEPS_MAX : neg_count[30:0];
        end else begin
            turn_mag = i_req.step_count[30:0];
        end
    end

    swds_coil_map u_coil_map (
        .i_port    (i_req.port_in),
        .i_mask    (i_pin_mask),
        .i_fwd     (r_dir),
        .i_release (!stepping),
        .o_port    (coil_port)
    );

    // Next state per request
    always_comb begin
        n_steps    = r_steps;
        n_dir      = r_dir;
        n_div_cnt  = r_div_cnt;
        n_div_rld  = r_div_rld;
        n_paused   = r_paused;
        port_write = 1'b0;
        case (i_req.req_type)
            swds_pkg::REQ_TICK: begin
                if (expire) begin
                    n_div_cnt  = r_div_rld;
                    port_write = 1'b1;
                    if (stepping) begin
                        n_steps = r_steps - 31'd1;
                    end
                end else begin
                    n_div_cnt = div_dec;
                end
            end
            swds_pkg::REQ_TURN: begin
                n_steps   = turn_mag;
                n_dir     = i_req.direction ^ i_req.step_count[31];
                n_div_rld = (i_req.tick_divisor == 16'd0) ? 16'd1 : i_req.tick_divisor;
                n_div_cnt = n_div_rld;
            end
            swds_pkg::REQ_STOP: begin
                n_steps = '0;
            end
            swds_pkg::REQ_PAUSE: begin
                n_paused = 1'b1;
            end
            swds_pkg::REQ_RESUME: begin
                n_paused = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Result of the staged request
    always_comb begin
        o_res.port_write = port_write;
        o_res.port_out   = port_write ? coil_port : 8'h00;
        o_res.is_ready   = (n_steps == '0);
        o_res.steps_left = n_steps;
    end

    // Commit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps   <= '0;
            r_dir     <= 1'b0;
            r_div_cnt <= DIV_RESET;
            r_div_rld <= DIV_RESET;
            r_paused  <= 1'b0;
        end else if (i_fire) begin
            r_steps   <= n_steps;
            r_dir     <= n_dir;
            r_div_cnt <= n_div_cnt;
            r_div_rld <= n_div_rld;
            r_paused  <= n_paused;
        end
    end

endmodule

`default_nettype wire

/* tb/stepper_wave_drive_sequencer_tb.sv */
`timescale 1ns / 1ps

module stepper_wave_drive_sequencer_tb;

    localparam int DEFAULT_DIVISOR = 16;
    localparam int ITEMS_PER_MASK  = 190;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 500;
    localparam int PRINT_LIMIT     = 40;

    // Request codes the block does not decode
    localparam logic [2:0] REQ_SPARE_5 = 3'd5;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef struct {
        swds_pkg::t_req req;
        bit             typed;
        swds_pkg::t_res want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    swds_cfg_if cfg_bus ();
    swds_req_if req_bus ();
    swds_res_if res_bus ();

    stepper_wave_drive_sequencer #(
        .DEFAULT_DIVISOR(DEFAULT_DIVISOR)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_req  (req_bus),
        .o_res  (res_bus)
    );

    // Motor state as the sequencer should hold it
    logic [7:0]  coil_mask     = swds_pkg::PIN_MASK_RESET;
    logic [30:0] steps_pending = '0;
    logic        fwd_dir       = 1'b0;
    logic        hold          = 1'b0;
    logic [15:0] div_count     = 16'(DEFAULT_DIVISOR);
    logic [15:0] div_reload    = 16'(DEFAULT_DIVISOR);

    swds_pkg::t_res pending_results[$];
    t_row directed_rows[$];
    logic [7:0] port_image = 8'h00;
    int  fail_count = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic report(string msg);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // Collect the masked port bits into a 4-bit phase, top set bit at phase bit 3
    function automatic logic [3:0] gather_coils(logic [7:0] port, logic [7:0] mask);
        logic [3:0] phase;
        int n;
        int k;
        int slot;
        phase = '0;
        n = $countones(mask);
        k = 0;
        for (int p = 0; p < 8; p++) begin
            if (mask[p]) begin
                slot = k + 4 - n;
                if (slot >= 0 && slot <= 3)
                    phase[slot] = port[p];
                k++;
            end
        end
        return phase;
    endfunction

    // Place pattern bit k on the k-th set mask bit
    function automatic logic [7:0] scatter_coils(logic [3:0] pattern, logic [7:0] mask);
        logic [7:0] bits;
        int k;
        bits = '0;
        k = 0;
        for (int p = 0; p < 8; p++) begin
            if (mask[p]) begin
                if (k < 4)
                    bits[p] = pattern[k];
                k++;
            end
        end
        return bits;
    endfunction

    function automatic logic [3:0] next_coils(logic [3:0] phase, logic fwd);
        case (phase)
            swds_pkg::PH_0001: return fwd ? swds_pkg::PH_0010 : swds_pkg::PH_1000;
            swds_pkg::PH_0010: return fwd ? swds_pkg::PH_0100 : swds_pkg::PH_0001;
            swds_pkg::PH_0100: return fwd ? swds_pkg::PH_1000 : swds_pkg::PH_0010;
            swds_pkg::PH_1000: return fwd ? swds_pkg::PH_0001 : swds_pkg::PH_0100;
            default:           return fwd ? swds_pkg::PH_0010 : swds_pkg::PH_1000;
        endcase
    endfunction

    // Advance the motor state by one request and return the port update it causes
    function automatic swds_pkg::t_res step_motor(swds_pkg::t_req r);
        swds_pkg::t_res res;
        logic [31:0] mag;
        logic [3:0]  pattern;
        res = '0;
        case (r.req_type)
            swds_pkg::REQ_TICK: begin
                div_count = div_count - 16'd1;
                if (div_count == 16'd0) begin
                    div_count = div_reload;
                    pattern = swds_pkg::PH_OFF;
                    if (steps_pending != '0 && !hold) begin
                        steps_pending = steps_pending - 31'd1;
                        pattern = next_coils(gather_coils(r.port_in, coil_mask), fwd_dir);
                    end
                    res.port_write = 1'b1;
                    res.port_out = (r.port_in & ~coil_mask) | scatter_coils(pattern, coil_mask);
                end
            end
            swds_pkg::REQ_TURN: begin
                fwd_dir = r.direction;
                mag = r.step_count;
                if (r.step_count < 0) begin
                    mag = 32'd0 - mag;
                    if (mag > {1'b0, swds_pkg::STEPS_MAX})
                        mag = {1'b0, swds_pkg::STEPS_MAX};
                    fwd_dir = ~fwd_dir;
                end
                steps_pending = mag[30:0];
                div_reload = (r.tick_divisor == 16'd0) ? 16'd1 : r.tick_divisor;
                div_count = div_reload;
            end
            swds_pkg::REQ_STOP: steps_pending = '0;
            swds_pkg::REQ_PAUSE: hold = 1'b1;
            swds_pkg::REQ_RESUME: hold = 1'b0;
            default: ;
        endcase
        res.is_ready = (steps_pending == '0);
        res.steps_left = steps_pending;
        return res;
    endfunction

    function automatic void add_row(logic [2:0] kind, logic [31:0] cnt, logic dir,
                                    logic [15:0] div, logic [7:0] port,
                                    bit typed, swds_pkg::t_res want);
        t_row row;
        row.req = '{kind, cnt, dir, div, port};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic swds_pkg::t_req make_random_req();
        swds_pkg::t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            r.req_type = swds_pkg::REQ_TICK;
        else if (pick < 72)
            r.req_type = swds_pkg::REQ_TURN;
        else if (pick < 78)
            r.req_type = swds_pkg::REQ_STOP;
        else if (pick < 86)
            r.req_type = swds_pkg::REQ_PAUSE;
        else if (pick < 95)
            r.req_type = swds_pkg::REQ_RESUME;
        else begin
            case ($urandom_range(0, 2))
                0: r.req_type = REQ_SPARE_5;
                1: r.req_type = REQ_SPARE_6;
                default: r.req_type = REQ_SPARE_7;
            endcase
        end

        // Mostly short moves, with the full range and the extremes now and then
        pick = $urandom_range(0, 9);
        if (pick < 6)
            r.step_count = $signed($urandom_range(0, 24)) - 12;
        else if (pick == 6)
            r.step_count = $urandom;
        else if (pick == 7) begin
            case ($urandom_range(0, 3))
                0: r.step_count = 32'h8000_0000;
                1: r.step_count = 32'h7FFF_FFFF;
                2: r.step_count = -1;
                default: r.step_count = 0;
            endcase
        end else
            r.step_count = $urandom_range(1, 40);

        r.direction = 1'($urandom_range(0, 1));

        // Keep most step periods short so the divider expires often
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.tick_divisor = 16'd0;
        else if (pick < 7)
            r.tick_divisor = 16'($urandom_range(1, 3));
        else if (pick == 7)
            r.tick_divisor = 16'($urandom_range(4, 8));
        else if (pick == 8)
            r.tick_divisor = 16'($urandom_range(0, 65535));
        else
            r.tick_divisor = 16'hFFFF;

        // Feed back the last written port most of the time
        r.port_in = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : port_image;
        return r;
    endfunction

    // Present one request, wait for it to be taken, and queue its expected result
    task automatic send_request(swds_pkg::t_req r, bit typed, swds_pkg::t_res want);
        int gap;
        swds_pkg::t_res guess;
        if ($urandom_range(0, 39) == 0)
            send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= r.req_type;
        req_bus.step_count   <= r.step_count;
        req_bus.direction    <= r.direction;
        req_bus.tick_divisor <= r.tick_divisor;
        req_bus.port_in      <= r.port_in;
        do @(posedge i_clk); while (!req_bus.ready);
        guess = step_motor(r);
        pending_results.push_back(typed ? want : guess);
        if (guess.port_write)
            port_image = guess.port_out;
    endtask

    task automatic write_mask(logic [7:0] mask);
        cfg_bus.valid    <= 1'b1;
        cfg_bus.pin_mask <= mask;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        coil_mask = mask;
    endtask

    // Drop the request line and wait until every result is back
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: stall at random, then compare with the oldest expectation
    initial begin
        int stall;
        swds_pkg::t_res want;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = ~recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending, port_out %02h",
                                 res_bus.port_out));
            end else begin
                want = pending_results.pop_front();
                if (res_bus.port_write !== want.port_write)
                    report($sformatf("port_write got %0b want %0b",
                                     res_bus.port_write, want.port_write));
                if (res_bus.port_out !== want.port_out)
                    report($sformatf("port_out got %02h want %02h",
                                     res_bus.port_out, want.port_out));
                if (res_bus.is_ready !== want.is_ready)
                    report($sformatf("is_ready got %0b want %0b",
                                     res_bus.is_ready, want.is_ready));
                if (res_bus.steps_left !== want.steps_left)
                    report($sformatf("steps_left got %0h want %0h",
                                     res_bus.steps_left, want.steps_left));
            end
        end
    end

    // Stop the run when nothing moves on any channel for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [7:0] mask_plan[$];
        swds_pkg::t_res none;

        req_bus.valid        <= 1'b0;
        req_bus.req_type     <= swds_pkg::REQ_TICK;
        req_bus.step_count   <= '0;
        req_bus.direction    <= 1'b0;
        req_bus.tick_divisor <= '0;
        req_bus.port_in      <= '0;
        res_bus.ready        <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.pin_mask     <= '0;
        i_rst_n              <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        none = '0;

        // Directed walk under the reset mask
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h00, 1, '{1'b0, 8'h00, 1'b1, 31'd0});
        add_row(swds_pkg::REQ_TURN, 3, 1'b1, 16'd0, 8'h00, 1, '{1'b0, 8'h00, 1'b0, 31'd3});
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h00, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'hA2, 0, none);
        add_row(swds_pkg::REQ_PAUSE, 0, 1'b0, 16'd0, 8'h00, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'hFF, 0, none);
        add_row(swds_pkg::REQ_RESUME, 0, 1'b0, 16'd0, 8'h00, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h5F, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h01, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h31, 0, none);
        add_row(swds_pkg::REQ_TURN, -5, 1'b1, 16'd2, 8'h00, 1, '{1'b0, 8'h00, 1'b0, 31'd5});
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h01, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h01, 0, none);
        add_row(swds_pkg::REQ_TURN, 2, 1'b0, 16'd1, 8'h00, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h04, 0, none);
        add_row(swds_pkg::REQ_TURN, 32'h8000_0000, 1'b0, 16'hFFFF, 8'h00, 1,
                '{1'b0, 8'h00, 1'b0, swds_pkg::STEPS_MAX});
        add_row(swds_pkg::REQ_TURN, 32'h7FFF_FFFF, 1'b1, 16'd1, 8'h00, 1,
                '{1'b0, 8'h00, 1'b0, swds_pkg::STEPS_MAX});
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h88, 0, none);
        add_row(swds_pkg::REQ_STOP, 0, 1'b0, 16'd0, 8'h00, 1, '{1'b0, 8'h00, 1'b1, 31'd0});
        add_row(REQ_SPARE_5, $urandom, 1'b1, 16'hFFFF, 8'hFF, 1, '{1'b0, 8'h00, 1'b1, 31'd0});
        add_row(REQ_SPARE_6, $urandom, 1'b0, 16'h0000, 8'h00, 1, '{1'b0, 8'h00, 1'b1, 31'd0});
        add_row(REQ_SPARE_7, $urandom, 1'b1, 16'h5A5A, 8'hA5, 1, '{1'b0, 8'h00, 1'b1, 31'd0});
        add_row(swds_pkg::REQ_TURN, -1, 1'b0, 16'd1, 8'h00, 0, none);
        add_row(swds_pkg::REQ_TICK, 0, 1'b0, 16'd0, 8'h00, 0, none);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random traffic under a run of pin masks, extremes included
        mask_plan = '{8'hFF, 8'h00, 8'hF0, 8'h3C, 8'h81, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), swds_pkg::PIN_MASK_RESET};
        foreach (mask_plan[m]) begin
            drain();
            write_mask(mask_plan[m]);
            repeat (ITEMS_PER_MASK)
                send_request(make_random_req(), 0, none);
        end
        drain();

        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
